>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the interval overlap counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset.
`define IOVC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define IOVC_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define IOVC_ASSERT(label, clk, rst, prop, msg)
`define IOVC_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> hw/rtl/iovc_pkg.sv
// Package: field widths, action and status codes, controller/datapath structs.
`timescale 1ns / 1ps

package iovc_pkg;

   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int HIT_W    = 11;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept_word;   // input word taken this cycle
      logic scan_start;    // query needs a store scan
      logic scan_step;     // issue one store read
      logic rsp_load;      // load the output register
      logic rsp_from_scan; // result comes from the held registers
   } iovc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_needed;   // current input word is a query that must scan
      logic last_addr;     // scan address is the last valid entry
   } iovc_sts_type;

endpackage

>>> hw/rtl/iovc_ctrl.sv
// Controller state machine: handshakes, scan sequencing, result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iovc_ctrl
   import iovc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  iovc_sts_type sts,
   output iovc_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.accept_word   = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.scan_needed) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else if (out_free) begin
                  cmd.rsp_load = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.rsp_load      = 1'b1;
               cmd.rsp_from_scan = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `IOVC_ASSERT(a_no_overwrite, clock, reset, cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten while waiting")
   `IOVC_NEVER(a_load_mid_scan, clock, reset, cmd.rsp_load && (state_ff == ST_SCAN || state_ff == ST_DRAIN), "result issued before scan finished")

endmodule

>>> hw/rtl/iovc_dp.sv
// Datapath: interval store, scan address, overlap compare and count, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iovc_dp
   import iovc_pkg::*;
#(
   parameter int MAX_INTERVALS = 1024
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic signed [VALUE_W-1:0]  req_range_start,
   input  logic signed [VALUE_W-1:0]  req_range_end,
   input  iovc_cmd_type               cmd,
   output iovc_sts_type               sts,
   output logic [HIT_W-1:0]           rsp_hit_count,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

   logic [2*VALUE_W-1:0] store_mem [MAX_INTERVALS];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic                      rd_valid_ff;
   logic [2*VALUE_W-1:0]      rd_data_ff;
   logic signed [VALUE_W-1:0] q_start_ff, q_end_ff;
   logic [HIT_W-1:0]          acc_ff, acc_in;
   logic [STATUS_W-1:0]       pend_status_ff;
   logic [HIT_W-1:0]          rsp_hit_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;

   logic                      store_full;
   logic                      range_empty;
   logic                      wr_en;
   logic [STATUS_W-1:0]       imm_status;
   logic signed [VALUE_W-1:0] rd_start, rd_end;
   logic                      hit;

   assign store_full  = (count_ff == CNT_MAX);
   assign range_empty = (req_range_end <= req_range_start);

   always_comb begin
      imm_status = STATUS_OK;
      if (req_action == ACT_LOAD) begin
         if (store_full) begin
            imm_status = STATUS_FULL;
         end else if (range_empty) begin
            imm_status = STATUS_EMPTY;
         end
      end
   end

   assign wr_en = cmd.accept_word && (req_action == ACT_LOAD) && !store_full && !range_empty;

   assign sts.scan_needed = (req_action == ACT_QUERY) && !range_empty && (count_ff != '0);
   assign sts.last_addr   = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);

   // Store count
   always_comb begin
      count_in = count_ff;
      if (cmd.accept_word && (req_action == ACT_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Scan address
   always_comb begin
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         addr_in = '0;
      end else if (cmd.scan_step) begin
         addr_in = addr_ff + IDX_W'(1);
      end
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[IDX_W-1:0]] <= {req_range_start, req_range_end};
      end
      rd_data_ff <= store_mem[addr_ff];
   end

   assign rd_start = $signed(rd_data_ff[2*VALUE_W-1:VALUE_W]);
   assign rd_end   = $signed(rd_data_ff[VALUE_W-1:0]);
   assign hit      = (rd_start < q_end_ff) && (rd_end > q_start_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.accept_word) begin
         acc_in = '0;
      end else if (rd_valid_ff && hit) begin
         acc_in = acc_ff + HIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= cmd.scan_step;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.accept_word) begin
         q_start_ff     <= req_range_start;
         q_end_ff       <= req_range_end;
         pend_status_ff <= imm_status;
      end
      if (cmd.rsp_load) begin
         if (cmd.rsp_from_scan) begin
            rsp_hit_ff    <= acc_ff;
            rsp_status_ff <= pend_status_ff;
         end else begin
            rsp_hit_ff    <= '0;
            rsp_status_ff <= imm_status;
         end
      end
   end

   assign rsp_hit_count = rsp_hit_ff;
   assign rsp_status    = rsp_status_ff;

   `IOVC_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_MAX, "store count above capacity")
   `IOVC_ASSERT(a_scan_in_range, clock, reset, cmd.scan_step |-> (CNT_W'(addr_ff) < count_ff), "scan read beyond loaded entries")

endmodule

>>> hw/rtl/interval_overlap_counter.sv
// Top level of the interval overlap counter: controller plus datapath.
`timescale 1ns / 1ps

//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/ready, action, range_start/end | in
//  rsp     | rsp_valid/ready, hit_count, status       | out
//
//  Clear and load: the result goes straight to the output register when it is free,
//    and the next word can follow at once; else the word waits in HOLD, req_ready low.
//  Query: the store is scanned through its single read port, one entry per cycle,
//    then the read pipe drains and the result goes out; no req word is taken meanwhile.
//  An empty query, or a query on an empty store, answers like a load.
//  Reset (synchronous) empties the store; entry contents are left as they are.
//  A stalled rsp side holds the finished word; one more req word is taken, then none.

module interval_overlap_counter
   import iovc_pkg::*;
#(
   parameter int MAX_INTERVALS = 1024
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [VALUE_W-1:0] req_range_start,
   input  logic signed [VALUE_W-1:0] req_range_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HIT_W-1:0]          rsp_hit_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   iovc_cmd_type cmd;
   iovc_sts_type sts;

   // Sequencer: idle / scan / drain of the read pipe / result hand-off
   iovc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, compare-and-count and output register
   iovc_dp #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_status      (rsp_status)
   );

endmodule

>>> tb/sv/interval_overlap_counter_test.sv
// Self-checking testbench for the interval overlap counter.
`timescale 1ns / 1ps

module interval_overlap_counter_test
   import iovc_pkg::*;
();

   localparam int MAX_INTERVALS = 1024;
   localparam int LIMIT_CYCLES  = 8_000_000;  // far beyond the slowest sane run
   localparam int HOLD_CYCLES   = 400;        // long rsp stall, fills the block

   // action 3 has no meaning; the block must answer it like a no-op
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [HIT_W-1:0]    hits;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_W-1:0]       req_action = ACT_CLEAR;
   logic signed [VALUE_W-1:0] req_range_start = '0;
   logic signed [VALUE_W-1:0] req_range_end = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [HIT_W-1:0]          rsp_hit_count;
   logic [STATUS_W-1:0]       rsp_status;

   // shadow copy of the interval store
   logic signed [VALUE_W-1:0] shadow_starts [MAX_INTERVALS];
   logic signed [VALUE_W-1:0] shadow_ends [MAX_INTERVALS];
   int                        shadow_fill = 0;

   outcome_type pending_outcomes [$];   // one per accepted word, oldest first
   outcome_type oldest;
   int          failures = 0;
   int          cycle_count = 0;

   // idling controls, changed per phase
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;

   interval_overlap_counter #(
      .MAX_INTERVALS(MAX_INTERVALS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit_count(rsp_hit_count),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // rsp side: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // result checker: each rsp word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected rsp word: hit_count %0d status %0d",
                   rsp_hit_count, rsp_status);
            failures++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_hit_count !== oldest.hits) begin
               $error("hit_count: expected %0d, got %0d", oldest.hits, rsp_hit_count);
               failures++;
            end
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_status);
               failures++;
            end
         end
      end
   end

   // Overlap count and store update for one accepted word.
   // Full store takes priority over an empty interval on a load.
   function automatic outcome_type count_and_store(input logic [ACTION_W-1:0] act,
                                                   input logic signed [VALUE_W-1:0] lo,
                                                   input logic signed [VALUE_W-1:0] hi);
      outcome_type res;
      int          overlaps;
      res.hits = '0;
      res.status = STATUS_OK;
      overlaps = 0;
      case (act)
         ACT_CLEAR: begin
            shadow_fill = 0;
         end
         ACT_LOAD: begin
            if (shadow_fill >= MAX_INTERVALS) begin
               res.status = STATUS_FULL;
            end else if (hi <= lo) begin
               res.status = STATUS_EMPTY;
            end else begin
               shadow_starts[shadow_fill] = lo;
               shadow_ends[shadow_fill] = hi;
               shadow_fill++;
            end
         end
         ACT_QUERY: begin
            // empty query overlaps nothing
            if (hi > lo) begin
               for (int i = 0; i < shadow_fill; i++) begin
                  if (shadow_starts[i] < hi && shadow_ends[i] > lo)
                     overlaps++;
               end
            end
            res.hits = overlaps[HIT_W-1:0];
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Offers one word, waits for acceptance and records what it must produce.
   // Valid is left high on return; a drain, or the next call while it idles, takes it down.
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic signed [VALUE_W-1:0] lo,
                            input logic signed [VALUE_W-1:0] hi);
      outcome_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_range_start <= lo;
      req_range_end <= hi;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = count_and_store(act, lo, hi);
      pending_outcomes.insert(pending_outcomes.size(), predicted);
   endtask

   // Sender goes quiet until every outstanding result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Values bunched in a narrow window so intervals overlap often,
   // with a share near both ends of the range and some fully random.
   function automatic logic signed [VALUE_W-1:0] random_point();
      int pick;
      int near;
      pick = $urandom_range(99);
      near = int'($urandom_range(400)) - 200;
      if (pick < 60)
         return near;
      if (pick < 75)
         return VAL_MAX - $urandom_range(20);
      if (pick < 90)
         return VAL_MIN + $urandom_range(20);
      return $urandom;
   endfunction

   // proper: start below end; otherwise end not above start
   function automatic void random_span(input bit proper,
                                       output logic signed [VALUE_W-1:0] lo,
                                       output logic signed [VALUE_W-1:0] hi);
      logic signed [VALUE_W-1:0] a;
      logic signed [VALUE_W-1:0] b;
      logic signed [VALUE_W-1:0] t;
      a = random_point();
      b = random_point();
      if (a > b) begin
         t = a;
         a = b;
         b = t;
      end
      if (proper) begin
         if (a == b) begin
            if (a == VAL_MAX)
               a = a - 1;
            else
               b = b + 1;
         end
         lo = a;
         hi = b;
      end else begin
         lo = b;
         hi = a;
      end
   endfunction

   // One random word: mostly loads and queries, a few clears, empties and
   // unused actions.
   task automatic send_random_word();
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
      int                        pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         send_word(ACT_CLEAR, $urandom, $urandom);
      end else if (pick < 8) begin
         send_word(ACT_UNUSED, $urandom, $urandom);
      end else if (pick < 55) begin
         random_span($urandom_range(9) != 0, lo, hi);
         send_word(ACT_LOAD, lo, hi);
      end else begin
         random_span($urandom_range(99) < 85, lo, hi);
         send_word(ACT_QUERY, lo, hi);
      end
   endtask

   task automatic test_empty_store();
      send_word(ACT_QUERY, VAL_MIN, VAL_MAX);
      drain_results();
   endtask

   // range ends, touching edges (half-open), empty loads and queries
   task automatic test_boundaries();
      send_word(ACT_LOAD, VAL_MIN, VAL_MAX);
      send_word(ACT_LOAD, -5, 5);
      send_word(ACT_LOAD, VAL_MAX - 1, VAL_MAX);
      send_word(ACT_LOAD, VAL_MIN, VAL_MIN + 1);
      send_word(ACT_LOAD, 7, 7);
      send_word(ACT_LOAD, VAL_MAX, VAL_MIN);
      send_word(ACT_QUERY, VAL_MIN, VAL_MAX);
      send_word(ACT_QUERY, 5, 9);
      send_word(ACT_QUERY, -10, -5);
      send_word(ACT_QUERY, 4, 5);
      send_word(ACT_QUERY, 3, 3);
      send_word(ACT_QUERY, 10, -10);
      send_word(ACT_QUERY, VAL_MAX - 1, VAL_MAX);
      send_word(ACT_QUERY, VAL_MIN, VAL_MIN + 1);
      drain_results();
   endtask

   task automatic test_unused_and_clear();
      send_word(ACT_UNUSED, '1, '1);
      send_word(ACT_UNUSED, '0, '0);
      send_word(ACT_CLEAR, '1, '0);
      send_word(ACT_QUERY, VAL_MIN, VAL_MAX);
      send_word(ACT_CLEAR, '0, '1);
      drain_results();
   endtask

   // rsp held off for a long stretch while words keep coming: the block
   // must back up and drop req_ready without losing anything
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left <= HOLD_CYCLES;
      for (int i = 0; i < 30; i++)
         send_random_word();
      drain_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int words);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < words; i++)
         send_random_word();
      drain_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_boundaries();
      test_unused_and_clear();
      test_backpressure();
      test_random_traffic(0, 0, 130);
      test_random_traffic(70, 0, 130);
      test_random_traffic(0, 70, 130);
      test_random_traffic(32, 32, 130);

      // allow a full scan's worth of cycles for any stray word
      drain_results();
      repeat (MAX_INTERVALS + 16) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
